/* rtl/core/i2a_pkg.sv */
// Shared constants, types and the digit-to-character map for the integer
// to ASCII radix converter. No dependencies.

package i2a_pkg;

    localparam int VALUE_BITS_DEF = 32;  // default conversion word width
    localparam int IN_VALUE_W     = 32;  // width of the value field on the input beat
    localparam int BASE_W         = 6;
    localparam int CHAR_W         = 8;
    localparam int DIV_STEP       = 8;   // quotient bits resolved per divider cycle

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd32;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_BASE = 1'b1;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Map a digit value below the base to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= BASE_DEC)
            c = CHAR_UPPER_A + {2'b00, d} - {2'b00, BASE_DEC};
        else
            c = CHAR_ZERO + {2'b00, d};
        return c;
    endfunction

endpackage

/* rtl/core/i2a_divider.sv */
// Shared radix divider: restoring division of a wide dividend by a 6-bit base,
// DIV_STEP quotient bits per cycle. Depends on i2a_pkg.

module i2a_divider #(
    parameter int DIVIDEND_W = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [i2a_pkg::BASE_W-1:0]    divisor,
    output logic [DIVIDEND_W-1:0]         quotient,
    output logic [i2a_pkg::BASE_W-1:0]    remainder,
    output i2a_pkg::div_stat_t            stat
);

    localparam int PASSES = DIVIDEND_W / i2a_pkg::DIV_STEP;
    localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;

    logic [DIVIDEND_W-1:0]      work_reg, work_next;
    logic [i2a_pkg::BASE_W-1:0] rem_reg, rem_next;
    logic [i2a_pkg::BASE_W-1:0] divisor_reg;
    logic [PW-1:0]              pass_reg;
    logic                       busy_reg;
    logic                       done_reg;

    // One pass, DIV_STEP times over: shift the dividend MSB into the remainder, trial subtract,
    // shift the quotient bit into the freed LSB.
    always_comb
    begin
        logic [i2a_pkg::BASE_W:0] trial;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < i2a_pkg::DIV_STEP; i++)
        begin
            trial     = {rem_next, work_next[DIVIDEND_W-1]};
            work_next = {work_next[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial        = trial - {1'b0, divisor_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[i2a_pkg::BASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            pass_reg    <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (start)
        begin
            work_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            pass_reg    <= PW'(PASSES - 1);
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            if (pass_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                pass_reg <= pass_reg - PW'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = work_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/core/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII radix converter: request sequencer, digit
// store and output register. Depends on i2a_pkg and i2a_divider.
//
//  channel  | dir | tdata                          | tuser        | tlast
//  ---------+-----+--------------------------------+--------------+------------
//  s_*      | in  | value[31:0], base[37:32], pad  | req_type     | -
//  m_*      | out | char_out[7:0]                  | status       | last char
//
//  From the accepting edge each digit of a nonzero value is one full division by the
//  base in the shared divider; a finish step then writes any minus sign, and each
//  character passes through the digit store read port (ST_READ, ST_SHOW, ST_WAIT)
//  on its way to the output register. Any output stall holds the sequencer back.
//  A bad base skips the divider and goes straight to the output register.
//  s_tready is high only when the sequencer is idle and the output register empty.
//  Reset clears the sequencer and output valid; the digit store is not cleared.

module integer_to_ascii_radix #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], base[37:32], zero[39:38]
    input  logic        s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out[7:0]
    output logic        m_tuser,   // status[0]
    output logic        m_tlast
);

    localparam int DW    = ((VALUE_BITS + i2a_pkg::DIV_STEP - 1) / i2a_pkg::DIV_STEP)
                           * i2a_pkg::DIV_STEP;
    localparam int DEPTH = VALUE_BITS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH,
        ST_READ,
        ST_SHOW,
        ST_WAIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [DW-1:0]                mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic                         dec_reg, dec_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic                         out_valid_reg, out_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_status_reg, out_status_next;

    logic [i2a_pkg::CHAR_W-1:0]   digit_store [DEPTH];
    logic [i2a_pkg::CHAR_W-1:0]   rd_data_reg;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [i2a_pkg::CHAR_W-1:0]   wr_data;

    logic [i2a_pkg::IN_VALUE_W-1:0] value_in;
    logic [i2a_pkg::BASE_W-1:0]   base_in;
    logic [VALUE_BITS-1:0]        raw;
    logic [VALUE_BITS-1:0]        mag_in;
    logic                         neg_in;
    logic                         base_ok;
    logic                         in_fire;
    logic                         out_fire;
    logic [CW-1:0]                cnt_fin;

    logic                         div_start;
    logic [DW-1:0]                div_quo;
    logic [i2a_pkg::BASE_W-1:0]   div_rem;
    i2a_pkg::div_stat_t           div_stat;
    logic [i2a_pkg::BASE_W-1:0]   base_reg;

    assign value_in = s_tdata[31:0];
    assign base_in  = s_tdata[37:32];

    generate
        if (VALUE_BITS <= i2a_pkg::IN_VALUE_W)
        begin : g_narrow
            assign raw = value_in[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign raw = {{(VALUE_BITS - i2a_pkg::IN_VALUE_W){1'b0}}, value_in};
        end
    endgenerate

    // Most negative value wraps to 2^(VALUE_BITS-1), which fits unsigned
    assign neg_in   = !s_tuser && raw[VALUE_BITS-1];
    assign mag_in   = neg_in ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
    assign base_ok  = base_in inside {[i2a_pkg::BASE_MIN:i2a_pkg::BASE_MAX]};
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign cnt_fin  = (neg_reg && dec_reg) ? count_reg + CW'(1) : count_reg;

    i2a_divider #(
        .DIVIDEND_W (DW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (state_reg == ST_IDLE ? DW'(mag_in) : div_quo),
        .divisor   (state_reg == ST_IDLE ? base_in : base_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        dec_next        = dec_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        out_valid_next  = out_fire ? 1'b0 : out_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        div_start       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = i2a_pkg::CHAR_ZERO;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next   = neg_in;
                    dec_next   = (base_in == i2a_pkg::BASE_DEC);
                    mag_next   = DW'(mag_in);
                    count_next = '0;
                    if (!base_ok)
                    begin
                        out_valid_next  = 1'b1;
                        out_char_next   = i2a_pkg::CHAR_NONE;
                        out_last_next   = 1'b1;
                        out_status_next = i2a_pkg::STATUS_BAD_BASE;
                    end
                    else if (mag_in == '0)
                    begin
                        // zero converts to a single '0'
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = i2a_pkg::CHAR_ZERO;
                        count_next = CW'(1);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = i2a_pkg::digit_char(div_rem);
                    count_next = count_reg + CW'(1);
                    mag_next   = div_quo;
                    if (div_quo == '0)
                        state_next = ST_FINISH;
                    else
                        div_start = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (neg_reg && dec_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = i2a_pkg::CHAR_MINUS;
                end
                count_next  = cnt_fin;
                rd_ptr_next = AW'(cnt_fin - CW'(1));
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid_next  = 1'b1;
                out_char_next   = rd_data_reg;
                out_last_next   = (rd_ptr_reg == '0);
                out_status_next = i2a_pkg::STATUS_OK;
                if (rd_ptr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg - AW'(1);
                    state_next  = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // advance once the shown character leaves
                if (out_fire)
                    state_next = ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            dec_reg        <= 1'b0;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= i2a_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            dec_reg        <= dec_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    // Hold the base for later digits
    always_ff @(posedge clk)
    begin
        if (in_fire)
            base_reg <= base_in;
    end

    // Digit store: least significant character at address 0
    always_ff @(posedge clk)
    begin
        if (wr_en)
            digit_store[wr_addr] <= wr_data;
        if (state_reg == ST_READ)
            rd_data_reg <= digit_store[rd_ptr_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("bad-base beat not marked last");

    a_ok_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata != i2a_pkg::CHAR_NONE))
        else $error("null character on a valid text beat");

    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("sequencer waits on an idle divider");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < CW'(DEPTH)))
        else $error("digit store write beyond depth");

    a_next_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (state_reg == ST_READ))
        else $error("no read issued after a non-final character");

endmodule

/* bench/testbench.sv */
// Self-checking bench for integer_to_ascii_radix: predicts the character stream
// of each request and checks every output beat. Depends on i2a_pkg and the RTL.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_SIGNED   = 1'b0;
    localparam logic REQ_UNSIGNED = 1'b1;
    localparam int   CYCLE_LIMIT  = 1500000;
    localparam int   DRAIN_CYCLES = 120;
    localparam int   HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       status;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    char_beat_t  pending_chars[$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          cycle_count = 0;
    int          requests_sent = 0;
    int          chars_checked = 0;
    int          bad_base_seen = 0;
    int          mismatch_count = 0;

    integer_to_ascii_radix i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d beats still expected", $realtime, pending_chars.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Long hold-off of the output side, armed by the backpressure test
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    // Work out the text of one request, most significant character first
    function automatic void predict_text(input logic req_type, input logic [31:0] value,
                                         input logic [5:0] base);
        logic [31:0] mag;
        logic [31:0] rem;
        logic        negative;
        logic [7:0]  digits[$];
        char_beat_t  beat;

        if (base < i2a_pkg::BASE_MIN || base > i2a_pkg::BASE_MAX)
        begin
            beat.ch = i2a_pkg::CHAR_NONE;
            beat.last = 1'b1;
            beat.status = i2a_pkg::STATUS_BAD_BASE;
            pending_chars.push_back(beat);
            return;
        end
        negative = (req_type == REQ_SIGNED) && value[31];
        // two's complement wraps the most negative word onto 2^31
        mag = negative ? (32'd0 - value) : value;
        do
        begin
            rem = mag % base;
            if (rem >= 32'd10)
                digits.push_front(8'(i2a_pkg::CHAR_UPPER_A + rem - 32'd10));
            else
                digits.push_front(8'(i2a_pkg::CHAR_ZERO + rem));
            mag = mag / base;
        end
        while (mag != 0);
        if (negative && base == i2a_pkg::BASE_DEC)
            digits.push_front(i2a_pkg::CHAR_MINUS);
        foreach (digits[k])
        begin
            beat.ch = digits[k];
            beat.last = (k == digits.size() - 1);
            beat.status = i2a_pkg::STATUS_OK;
            pending_chars.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            chars_checked++;
            if (m_tuser == i2a_pkg::STATUS_BAD_BASE)
                bad_base_seen++;
            if (pending_chars.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected beat: expected none, got char %h last %b status %b",
                         $realtime, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last || m_tuser !== want.status)
                begin
                    mismatch_count++;
                    $display({"%0t: mismatch: expected char %h last %b status %b,",
                              " got char %h last %b status %b"},
                             $realtime, want.ch, want.last, want.status,
                             m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    task automatic send_request(input logic req_type, input logic [31:0] value,
                                input logic [5:0] base);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, base, value};
        s_tuser  <= req_type;
        do
            @(posedge clk);
        while (!s_tready);
        predict_text(req_type, value, base);
        requests_sent++;
    endtask

    // Drop valid and hold the input until every expected beat is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        logic [31:0] value;
        logic [5:0]  base;
        case ($urandom_range(3))
            0: value = $urandom;
            1: value = $urandom_range(0, 40);
            2: value = ($urandom_range(1) ? 32'h8000_0000 : 32'hFFFF_FFFF)
                       ^ 32'($urandom_range(7));
            default: value = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(99) < 15)
            base = $urandom_range(1) ? 6'($urandom_range(1)) : 6'($urandom_range(33, 63));
        else if ($urandom_range(3) == 0)
            base = i2a_pkg::BASE_DEC;
        else
            base = 6'($urandom_range(i2a_pkg::BASE_MIN, i2a_pkg::BASE_MAX));
        send_request(1'($urandom_range(1)), value, base);
    endtask

    task automatic test_edge_values();
        send_request(REQ_SIGNED,   32'd0,         i2a_pkg::BASE_DEC);
        send_request(REQ_UNSIGNED, 32'd0,         i2a_pkg::BASE_MIN);
        send_request(REQ_UNSIGNED, 32'hFFFF_FFFF, i2a_pkg::BASE_MIN);
        send_request(REQ_SIGNED,   32'hFFFF_FFFF, i2a_pkg::BASE_DEC);
        send_request(REQ_SIGNED,   32'h8000_0000, i2a_pkg::BASE_DEC);
        send_request(REQ_SIGNED,   32'h8000_0000, 6'd16);
        send_request(REQ_SIGNED,   32'h8000_0000, i2a_pkg::BASE_MIN);
        send_request(REQ_UNSIGNED, 32'h8000_0000, i2a_pkg::BASE_DEC);
        send_request(REQ_SIGNED,   32'h7FFF_FFFF, i2a_pkg::BASE_DEC);
        send_request(REQ_UNSIGNED, 32'hFFFF_FFFF, i2a_pkg::BASE_MAX);
        send_request(REQ_UNSIGNED, 32'hFFFF_FFFF, i2a_pkg::BASE_DEC);
        // negative outside base 10 carries no sign
        send_request(REQ_SIGNED,   32'hFFFF_FF85, 6'd16);
        send_request(REQ_UNSIGNED, 32'hABCD_EF01, 6'd16);
        send_request(REQ_SIGNED,   32'd12345,     6'd3);
        send_request(REQ_UNSIGNED, 32'd31,        i2a_pkg::BASE_MAX);
        send_request(REQ_SIGNED,   32'd9,         i2a_pkg::BASE_DEC);
        wait_drained();
    endtask

    task automatic test_bad_base();
        send_request(REQ_SIGNED,   32'd123,       6'd0);
        send_request(REQ_UNSIGNED, 32'hFFFF_FFFF, 6'd1);
        send_request(REQ_SIGNED,   32'h8000_0000, 6'd33);
        send_request(REQ_UNSIGNED, 32'd0,         6'd63);
        send_request(REQ_SIGNED,   32'd35,        6'd36);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            send_random_request();
        wait_drained();
    endtask

    // Output held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req <= ~hold_req;
        send_request(REQ_UNSIGNED, 32'hFFFF_FFFF, i2a_pkg::BASE_MIN);
        repeat (7)
            send_random_request();
        wait_drained();
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_bad_base();
        test_random_traffic(0, 0, 55);
        test_random_traffic(58, 0, 55);
        test_random_traffic(0, 58, 55);
        test_random_traffic(14, 14, 55);
        test_backpressure();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("summary: %0d requests in signed, unsigned and bad-base forms over four idle mixes",
                 requests_sent);
        $display("summary: %0d characters checked, %0d bad-base beats, %0d mismatches",
                 chars_checked, bad_base_seen, mismatch_count);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
